FILE: design/wfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wfs_pkg;

   localparam int MaxWaypointsDef = 1024;
   localparam int CordicStepsDef  = 16;
   localparam int AtanEntries     = 24;

   localparam int CoordW  = 32;
   localparam int DiffW   = 33;
   localparam int GainW   = 16;
   localparam int RadiusW = 31;
   localparam int QuatW   = 16;
   localparam int IndexW  = 11;
   localparam int CordW   = 36;
   localparam int AngW    = 34;
   localparam int MulW    = 34;
   localparam int ProdW   = 68;

   localparam logic [RadiusW-1:0] RadiusReset = 31'd32768;
   localparam logic [GainW-1:0]   GainReset   = 16'd256;
   localparam logic [AngW-1:0]    HalfPiQ30   = 34'd1686629713;
   localparam logic [29:0]        InvGainQ30  = 30'h26DD3B6A;

   typedef enum logic [1:0] {
      MODE_PATH = 2'd0,
      MODE_POSE = 2'd1,
      MODE_TICK = 2'd2
   } mode_type;

   typedef enum logic [0:0] {
      CSR_RADIUS = 1'b0,
      CSR_GAIN   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]               mode;
      logic                     start_path;
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
   } item_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_status_type;

   function automatic logic [AngW-1:0] atan_entry(input logic [4:0] i);
      logic [AngW-1:0] r;
      case (i)
         5'd0:    r = 34'h03243F6A8;
         5'd1:    r = 34'h01DAC6705;
         5'd2:    r = 34'h00FADBAFC;
         5'd3:    r = 34'h007F56EA6;
         5'd4:    r = 34'h003FEAB76;
         5'd5:    r = 34'h001FFD55B;
         5'd6:    r = 34'h000FFFAAA;
         5'd7:    r = 34'h0007FFF55;
         5'd8:    r = 34'h0003FFFEA;
         5'd9:    r = 34'h0001FFFFD;
         5'd10:   r = 34'h0000FFFFF;
         5'd11:   r = 34'h00007FFFF;
         5'd12:   r = 34'h00003FFFF;
         5'd13:   r = 34'h00001FFFF;
         5'd14:   r = 34'h00000FFFF;
         5'd15:   r = 34'h000007FFF;
         5'd16:   r = 34'h000003FFF;
         5'd17:   r = 34'h000001FFF;
         5'd18:   r = 34'h000000FFF;
         5'd19:   r = 34'h0000007FF;
         5'd20:   r = 34'h0000003FF;
         5'd21:   r = 34'h0000001FF;
         5'd22:   r = 34'h0000000FF;
         5'd23:   r = 34'h00000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/waypoint_follower_setpoint.sv
// Waypoint follower setpoint generator.
// Input channel req_*: one transaction per item. req_mode selects a path point
// (req_start_path starts a new route), a pose update or a publish tick.
// Result channel rsp_*: one transaction per tick that has a valid target,
// carrying the Q16.16 setpoint, the Q1.15 orientation quaternion and the index
// of the tracked waypoint. Other items produce no result.
// csr_*: write accept_radius (index 0) or track_gain (index 1) while idle.
// A two-entry queue sits between the input and the execution sequencer, so
// transactions are taken while the sequencer works. A tick is bound by the
// single shared CORDIC unit, run four times (two vectoring, two rotation passes).
// Results are held in an output register; a stalled receiver stalls the
// sequencer only once a second result is ready, then the queue fills and
// req_ready drops. Reset clears the route, sets the target index to 1, clears
// the pose and loads the default radius and gain; no memory clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module waypoint_follower_setpoint import wfs_pkg::*; #(
   parameter int MAX_WAYPOINTS = MaxWaypointsDef,
   parameter int CORDIC_STEPS  = CordicStepsDef
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_mode,
   input  wire logic                req_start_path,
   input  wire logic signed [31:0]  req_pos_x,
   input  wire logic signed [31:0]  req_pos_y,
   input  wire logic signed [31:0]  req_pos_z,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [31:0]       rsp_set_x,
   output logic signed [31:0]       rsp_set_y,
   output logic signed [31:0]       rsp_set_z,
   output logic signed [15:0]       rsp_quat_w,
   output logic signed [15:0]       rsp_quat_x,
   output logic signed [15:0]       rsp_quat_y,
   output logic signed [15:0]       rsp_quat_z,
   output logic [10:0]              rsp_target_index,
   input  wire logic                csr_we,
   input  wire logic [0:0]          csr_index,
   input  wire logic [30:0]         csr_wdata
);

   item_type req_item, q_item;
   logic     q_valid, q_pop;

   assign req_item.mode       = req_mode;
   assign req_item.start_path = req_start_path;
   assign req_item.x          = req_pos_x;
   assign req_item.y          = req_pos_y;
   assign req_item.z          = req_pos_z;

   wfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   wfs_back #(
      .MAX_WAYPOINTS (MAX_WAYPOINTS),
      .CORDIC_STEPS  (CORDIC_STEPS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_set_x        (rsp_set_x),
      .rsp_set_y        (rsp_set_y),
      .rsp_set_z        (rsp_set_z),
      .rsp_quat_w       (rsp_quat_w),
      .rsp_quat_x       (rsp_quat_x),
      .rsp_quat_y       (rsp_quat_y),
      .rsp_quat_z       (rsp_quat_z),
      .rsp_target_index (rsp_target_index)
   );

endmodule
`default_nettype wire

FILE: design/wfs_front.sv
`timescale 1ns / 1ps
`default_nettype none
module wfs_front import wfs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire item_type req_item,
   output logic          q_valid,
   output item_type      q_item,
   input  wire logic     q_pop
);

   localparam int Depth = 2;

   item_type   q_ff [Depth];
   logic [0:0] head_ff, head_in, tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_ready = (count_ff != 2'(Depth));
   assign push      = req_valid && req_ready &&
                      (req_item.mode inside {MODE_PATH, MODE_POSE, MODE_TICK});
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_ff[head_ff];

   always_comb begin
      head_in  = q_pop ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= req_item;
      end
   end

endmodule
`default_nettype wire

FILE: design/wfs_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module wfs_cordic import wfs_pkg::*; #(
   parameter int CORDIC_STEPS = CordicStepsDef
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cordic_cmd_type          cmd,
   input  wire logic signed [CordW-1:0] x_in,
   input  wire logic signed [CordW-1:0] y_in,
   input  wire logic signed [AngW-1:0]  z_in,
   output cordic_status_type            status,
   output logic signed [CordW-1:0]      x_out,
   output logic signed [CordW-1:0]      y_out,
   output logic signed [AngW-1:0]       z_out
);

   localparam int StepW = $clog2(CORDIC_STEPS + 1);

   logic [StepW-1:0]       step_ff, step_in;
   logic                   busy_ff, busy_in, done_ff, done_in;
   logic                   vec_ff, vec_in, zero_ff, zero_in;
   logic signed [CordW-1:0] x_ff, x_in_r, y_ff, y_in_r, xs, ys;
   logic signed [AngW-1:0]  z_ff, z_in_r, at;

   always_comb begin
      xs       = x_ff >>> step_ff;
      ys       = y_ff >>> step_ff;
      at       = atan_entry(5'(step_ff));
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      vec_in   = vec_ff;
      zero_in  = zero_ff;
      x_in_r   = x_ff;
      y_in_r   = y_ff;
      z_in_r   = z_ff;
      if (cmd.start) begin
         vec_in  = cmd.vectoring;
         zero_in = cmd.vectoring && (x_in == '0) && (y_in == '0);
         busy_in = 1'b1;
         step_in = '0;
         if (cmd.vectoring && x_in[CordW-1]) begin
            if (!y_in[CordW-1]) begin
               x_in_r = y_in;
               y_in_r = -x_in;
               z_in_r = HalfPiQ30;
            end else begin
               x_in_r = -y_in;
               y_in_r = x_in;
               z_in_r = -HalfPiQ30;
            end
         end else begin
            x_in_r = x_in;
            y_in_r = y_in;
            z_in_r = z_in;
         end
      end else if (busy_ff) begin
         if (vec_ff ? !y_ff[CordW-1] : z_ff[AngW-1]) begin
            x_in_r = x_ff + ys;
            y_in_r = y_ff - xs;
            z_in_r = vec_ff ? z_ff + at : z_ff + at;
         end else begin
            x_in_r = x_ff - ys;
            y_in_r = y_ff + xs;
            z_in_r = z_ff - at;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == StepW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff  <= vec_in;
      zero_ff <= zero_in;
      x_ff    <= x_in_r;
      y_ff    <= y_in_r;
      z_ff    <= z_in_r;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign x_out       = x_ff;
   assign y_out       = y_ff;
   assign z_out       = zero_ff ? '0 : z_ff;

endmodule
`default_nettype wire

FILE: design/wfs_back.sv
`timescale 1ns / 1ps
`default_nettype none
module wfs_back import wfs_pkg::*; #(
   parameter int MAX_WAYPOINTS = MaxWaypointsDef,
   parameter int CORDIC_STEPS  = CordicStepsDef
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [0:0]              csr_index,
   input  wire logic [RadiusW-1:0]      csr_wdata,
   input  wire logic                    q_valid,
   input  wire item_type                q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [CoordW-1:0]     rsp_set_x,
   output logic signed [CoordW-1:0]     rsp_set_y,
   output logic signed [CoordW-1:0]     rsp_set_z,
   output logic signed [QuatW-1:0]      rsp_quat_w,
   output logic signed [QuatW-1:0]      rsp_quat_x,
   output logic signed [QuatW-1:0]      rsp_quat_y,
   output logic signed [QuatW-1:0]      rsp_quat_z,
   output logic [IndexW-1:0]            rsp_target_index
);

   localparam int AW     = $clog2(MAX_WAYPOINTS);
   localparam int LW     = $clog2(MAX_WAYPOINTS + 1);
   localparam int EntryW = 3 * CoordW;

   typedef enum logic [4:0] {
      S_IDLE, S_DIFF, S_PX, S_PY, S_PZ, S_PR, S_PCMP,
      S_GX, S_GY, S_GZ, S_VEC1, S_W1, S_SC1, S_SC2, S_SC3,
      S_W2, S_W3, S_W4, S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [EntryW-1:0] route_mem [MAX_WAYPOINTS];
   logic [EntryW-1:0] rd_ff;

   logic [LW-1:0]            len_ff, len_in, ptr_ff, ptr_in, eff_len;
   logic                     have_ff, have_in, tgt_ok, wr_en, is_path, load;
   logic signed [CoordW-1:0] pose_x_ff, pose_y_ff, pose_z_ff;
   logic [RadiusW-1:0]       radius_ff;
   logic [GainW-1:0]         gain_ff;
   item_type                 item_ff;
   logic signed [CoordW-1:0] tgt_x, tgt_y, tgt_z;
   logic signed [DiffW-1:0]  d_x, d_y, d_z, dx_ff, dy_ff, dz_ff;
   logic signed [MulW-1:0]   mul_a, mul_b;
   logic signed [ProdW-1:0]  prod_ff, hic_ff, scale_r;
   logic [65:0]              acc_ff;
   logic signed [CoordW-1:0] setx_ff, sety_ff, setz_ff;
   logic signed [QuatW-1:0]  qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [AngW-1:0]   yaw_ff, pitch_ff;
   logic signed [CordW-1:0]  mag_ff;
   logic signed [MulW-1:0]   cy_ff, sy_ff, cp_ff, sp_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LW+IndexW-1:0]     ptr_ext;

   cordic_cmd_type          cmd;
   cordic_status_type       cstat;
   logic signed [CordW-1:0] c_x, c_y, cx_out, cy_out;
   logic signed [AngW-1:0]  c_z, cz_out;

   wfs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .x_in   (c_x),
      .y_in   (c_y),
      .z_in   (c_z),
      .status (cstat),
      .x_out  (cx_out),
      .y_out  (cy_out),
      .z_out  (cz_out)
   );

   function automatic logic [CoordW-1:0] mag32(input logic signed [DiffW-1:0] d);
      logic signed [DiffW-1:0] n;
      n = d[DiffW-1] ? -d : d;
      return n[CoordW-1:0];
   endfunction

   function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [ProdW-1:0] t);
      logic signed [CoordW-1:0] r;
      if (t[ProdW-1:CoordW-1] == '0 || t[ProdW-1:CoordW-1] == '1) begin
         r = t[CoordW-1:0];
      end else begin
         r = t[ProdW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [QuatW-1:0] q15(input logic signed [ProdW-1:0] p);
      logic signed [ProdW-1:0] v;
      logic signed [QuatW-1:0] r;
      v = (p + (ProdW'(1) <<< 44)) >>> 45;
      if (v[ProdW-1:QuatW-1] == '0 || v[ProdW-1:QuatW-1] == '1) begin
         r = v[QuatW-1:0];
      end else begin
         r = v[ProdW-1] ? {1'b1, {(QuatW-1){1'b0}}} : {1'b0, {(QuatW-1){1'b1}}};
      end
      return r;
   endfunction

   assign tgt_ok  = have_ff && (ptr_ff < len_ff);
   assign is_path = (q_item.mode == MODE_PATH);
   assign eff_len = q_item.start_path ? '0 : len_ff;
   assign tgt_x   = rd_ff[EntryW-1 -: CoordW];
   assign tgt_y   = rd_ff[2*CoordW-1 -: CoordW];
   assign tgt_z   = rd_ff[CoordW-1:0];
   assign scale_r = (hic_ff + (prod_ff >>> 15)) >>> 15;
   assign load    = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (item_ff.mode == MODE_POSE) begin
         d_x = {item_ff.x[CoordW-1], item_ff.x} - {tgt_x[CoordW-1], tgt_x};
         d_y = {item_ff.y[CoordW-1], item_ff.y} - {tgt_y[CoordW-1], tgt_y};
         d_z = {item_ff.z[CoordW-1], item_ff.z} - {tgt_z[CoordW-1], tgt_z};
      end else begin
         d_x = {tgt_x[CoordW-1], tgt_x} - {pose_x_ff[CoordW-1], pose_x_ff};
         d_y = {tgt_y[CoordW-1], tgt_y} - {pose_y_ff[CoordW-1], pose_y_ff};
         d_z = {tgt_z[CoordW-1], tgt_z} - {pose_z_ff[CoordW-1], pose_z_ff};
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && !is_path && tgt_ok) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF:  state_in = (item_ff.mode == MODE_POSE) ? S_PX : S_GX;
         S_PX:    state_in = S_PY;
         S_PY:    state_in = S_PZ;
         S_PZ:    state_in = S_PR;
         S_PR:    state_in = S_PCMP;
         S_PCMP:  state_in = S_IDLE;
         S_GX:    state_in = S_GY;
         S_GY:    state_in = S_GZ;
         S_GZ:    state_in = S_VEC1;
         S_VEC1:  state_in = S_W1;
         S_W1:    state_in = cstat.done ? S_SC1 : S_W1;
         S_SC1:   state_in = S_SC2;
         S_SC2:   state_in = S_SC3;
         S_SC3:   state_in = S_W2;
         S_W2:    state_in = cstat.done ? S_W3 : S_W2;
         S_W3:    state_in = cstat.done ? S_W4 : S_W3;
         S_W4:    state_in = cstat.done ? S_Q0 : S_W4;
         S_Q0:    state_in = S_Q1;
         S_Q1:    state_in = S_Q2;
         S_Q2:    state_in = S_Q3;
         S_Q3:    state_in = S_Q4;
         S_Q4:    state_in = S_OUT;
         S_OUT:   state_in = load ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = (state_ff == S_IDLE) && q_valid;
      wr_en         = q_pop && is_path && (eff_len < LW'(MAX_WAYPOINTS));
      cmd.start     = 1'b0;
      cmd.vectoring = 1'b0;
      c_x           = '0;
      c_y           = '0;
      c_z           = '0;
      mul_a         = '0;
      mul_b         = '0;
      case (state_ff)
         S_PX: begin
            mul_a = {2'b0, mag32(dx_ff)};
            mul_b = {2'b0, mag32(dx_ff)};
         end
         S_PY: begin
            mul_a = {2'b0, mag32(dy_ff)};
            mul_b = {2'b0, mag32(dy_ff)};
         end
         S_PZ: begin
            mul_a = {2'b0, mag32(dz_ff)};
            mul_b = {2'b0, mag32(dz_ff)};
         end
         S_PR: begin
            mul_a = {3'b0, radius_ff};
            mul_b = {3'b0, radius_ff};
         end
         S_GX: begin
            mul_a = {18'b0, gain_ff};
            mul_b = {dx_ff[DiffW-1], dx_ff};
         end
         S_GY: begin
            mul_a = {18'b0, gain_ff};
            mul_b = {dy_ff[DiffW-1], dy_ff};
         end
         S_GZ: begin
            mul_a = {18'b0, gain_ff};
            mul_b = {dz_ff[DiffW-1], dz_ff};
         end
         S_VEC1: begin
            cmd.start     = 1'b1;
            cmd.vectoring = 1'b1;
            c_x           = {{(CordW-DiffW){dx_ff[DiffW-1]}}, dx_ff};
            c_y           = {{(CordW-DiffW){dy_ff[DiffW-1]}}, dy_ff};
         end
         S_SC1: begin
            mul_a = {13'b0, mag_ff[CordW-1:15]};
            mul_b = {4'b0, InvGainQ30};
         end
         S_SC2: begin
            mul_a = {19'b0, mag_ff[14:0]};
            mul_b = {4'b0, InvGainQ30};
         end
         S_SC3: begin
            cmd.start     = 1'b1;
            cmd.vectoring = 1'b1;
            c_x           = (mag_ff > 0) ? scale_r[CordW-1:0] : '0;
            c_y           = {{(CordW-DiffW){dz_ff[DiffW-1]}}, dz_ff};
         end
         S_W2: begin
            cmd.start = cstat.done;
            c_x       = {6'b0, InvGainQ30};
            c_z       = yaw_ff >>> 1;
         end
         S_W3: begin
            cmd.start = cstat.done;
            c_x       = {6'b0, InvGainQ30};
            c_z       = pitch_ff >>> 1;
         end
         S_Q0: begin
            mul_a = cp_ff;
            mul_b = cy_ff;
         end
         S_Q1: begin
            mul_a = sp_ff;
            mul_b = sy_ff;
         end
         S_Q2: begin
            mul_a = sp_ff;
            mul_b = cy_ff;
         end
         S_Q3: begin
            mul_a = cp_ff;
            mul_b = sy_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      len_in  = len_ff;
      ptr_in  = ptr_ff;
      have_in = have_ff;
      if (q_pop && is_path) begin
         if (q_item.start_path) begin
            have_in = 1'b1;
            ptr_in  = LW'(1);
         end
         len_in = wr_en ? eff_len + 1'b1 : eff_len;
      end else if (state_ff == S_PCMP && acc_ff < {4'b0, prod_ff[61:0]}) begin
         ptr_in = ptr_ff + 1'b1;
      end
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         ptr_ff       <= LW'(1);
         have_ff      <= 1'b0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_z_ff    <= '0;
         radius_ff    <= RadiusReset;
         gain_ff      <= GainReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_PCMP) begin
            pose_x_ff <= item_ff.x;
            pose_y_ff <= item_ff.y;
            pose_z_ff <= item_ff.z;
         end
         if (csr_we && csr_index == CSR_RADIUS) begin
            radius_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_GAIN) begin
            gain_ff <= csr_wdata[GainW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem[eff_len[AW-1:0]] <= {q_item.x, q_item.y, q_item.z};
      end
      rd_ff <= route_mem[ptr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (q_pop) begin
         item_ff <= q_item;
      end
      case (state_ff)
         S_DIFF: begin
            dx_ff <= d_x;
            dy_ff <= d_y;
            dz_ff <= d_z;
         end
         S_PY:   acc_ff <= {2'b0, prod_ff[63:0]};
         S_PZ:   acc_ff <= acc_ff + {2'b0, prod_ff[63:0]};
         S_PR:   acc_ff <= acc_ff + {2'b0, prod_ff[63:0]};
         S_GY:   setx_ff <= sat_coord((prod_ff >>> 8) + ProdW'(pose_x_ff));
         S_GZ:   sety_ff <= sat_coord((prod_ff >>> 8) + ProdW'(pose_y_ff));
         S_VEC1: setz_ff <= sat_coord((prod_ff >>> 8) + ProdW'(pose_z_ff));
         S_W1: begin
            yaw_ff <= cz_out;
            mag_ff <= cx_out;
         end
         S_SC2:  hic_ff <= prod_ff;
         S_W2:   pitch_ff <= cz_out;
         S_W3: begin
            cy_ff <= cx_out[MulW-1:0];
            sy_ff <= cy_out[MulW-1:0];
         end
         S_W4: begin
            cp_ff <= cx_out[MulW-1:0];
            sp_ff <= cy_out[MulW-1:0];
         end
         S_Q1:   qw_ff <= q15(prod_ff);
         S_Q2:   qx_ff <= q15(-prod_ff);
         S_Q3:   qy_ff <= q15(prod_ff);
         S_Q4:   qz_ff <= q15(prod_ff);
         default: begin
         end
      endcase
   end

   assign ptr_ext = {{IndexW{1'b0}}, ptr_ff};

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_set_x        <= setx_ff;
         rsp_set_y        <= sety_ff;
         rsp_set_z        <= setz_ff;
         rsp_quat_w       <= qw_ff;
         rsp_quat_x       <= qx_ff;
         rsp_quat_y       <= qy_ff;
         rsp_quat_z       <= qz_ff;
         rsp_target_index <= ptr_ext[IndexW-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_ptr_in_route: assert property (@(posedge clock) disable iff (reset)
      have_ff |-> ptr_ff <= len_ff)
      else $error("tracked index beyond route length");

   a_cordic_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !cstat.busy)
      else $error("cordic started while busy");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(MAX_WAYPOINTS))
      else $error("route length over capacity");

endmodule
`default_nettype wire
